/* src/ile_pkg.sv */
package ile_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         action;
    logic [4:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [3:0]  found_at;
    logic [4:0]  length;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL,
    ST_RD,
    ST_FIND,
    ST_DONE
  } state_e;

endpackage

/* src/ile_if.sv */
interface ile_req_if import ile_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*;;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/ile_ram.sv */
module ile_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/indexed_list_engine.sv */
// Channel  Dir  Handshake      Payload
// req_i    in   valid/ready    action, position, value
// rsp_o    out  valid/ready    ok, data_out, found_at, length
//
// One request at a time; req_i.ready is high only while idle.
// Insert moves the entries from position on up by one, the last first, then writes the
// value; delete moves the entries above position down by one; read fetches one entry;
// find scans from entry 0 until a match or the end of the list. One word moves per
// cycle, as the entry RAM has one read port.
// Reset (async, active low) empties the list; entries are not cleared.
// A response held by rsp_o.ready stalls the block in its done state.
module indexed_list_engine import ile_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  ile_req_if.sink    req_i,
  ile_rsp_if.source  rsp_o
);

  state_e                state_q, state_d;
  logic [4:0]            pos_q, pos_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic                  pend_q, pend_d;
  logic [CNT_W-1:0]      count_q, count_d;
  rsp_t                  res_q, res_d;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  acc;
  logic                  ins_ok, rng_ok;
  logic                  idx_at_pos, del_more, hit_now, scan_end;
  logic [CNT_W-1:0]      idx_inc, idx_dec, cnt_inc, cnt_dec;
  logic [ADDR_W-1:0]     pos_a;

  ile_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = (state_q == ST_DONE);
  assign rsp_o.payload   = res_q;
  assign acc             = req_i.valid && req_i.ready;

  assign ins_ok = (32'(req_i.payload.position) <= 32'(count_q)) && (32'(count_q) < DEPTH);
  assign rng_ok = (32'(req_i.payload.position) < 32'(count_q));

  assign idx_inc    = idx_q + CNT_W'(1);
  assign idx_dec    = idx_q - CNT_W'(1);
  assign cnt_inc    = count_q + CNT_W'(1);
  assign cnt_dec    = count_q - CNT_W'(1);
  assign pos_a      = ADDR_W'(pos_q);
  assign idx_at_pos = (32'(idx_q) == 32'(pos_q));
  assign del_more   = (idx_inc < count_q);
  assign hit_now    = pend_q && (ram_rdata == word_q);
  assign scan_end   = (idx_q == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_i.payload.action)
            OP_INSERT: state_d = ins_ok ? ST_INS : ST_DONE;
            OP_DELETE: state_d = rng_ok ? ST_DEL : ST_DONE;
            OP_READ:   state_d = rng_ok ? ST_RD  : ST_DONE;
            default:   state_d = ST_FIND;
          endcase
        end
      end
      ST_INS: begin
        if (idx_at_pos && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DEL: begin
        if (!del_more && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_RD: begin
        if (pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_FIND: begin
        if (hit_now || scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    pos_d     = pos_q;
    word_d    = word_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    pend_d    = pend_q;
    count_d   = count_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[ADDR_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          pos_d  = req_i.payload.position;
          word_d = DATA_WIDTH'(req_i.payload.value);
          pend_d = 1'b0;
          case (req_i.payload.action)
            OP_INSERT: idx_d = count_q;
            OP_FIND:   idx_d = '0;
            default:   idx_d = CNT_W'(req_i.payload.position);
          endcase
          res_d = '{ok: 1'b0, data_out: '0, found_at: '0, length: 5'(count_q)};
        end
      end
      ST_INS: begin
        if (!idx_at_pos) begin
          // move entry idx-1 up to idx; write of the previous move overlaps
          ram_re    = 1'b1;
          ram_raddr = idx_dec[ADDR_W-1:0];
          ram_we    = pend_q;
          pend_d    = 1'b1;
          addr_d    = idx_q[ADDR_W-1:0];
          idx_d     = idx_dec;
        end else if (pend_q) begin
          ram_we = 1'b1;
          pend_d = 1'b0;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = pos_a;
          ram_wdata    = word_q;
          count_d      = cnt_inc;
          res_d.ok     = 1'b1;
          res_d.length = 5'(cnt_inc);
        end
      end
      ST_DEL: begin
        if (del_more) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[ADDR_W-1:0];
          ram_we    = pend_q;
          pend_d    = 1'b1;
          addr_d    = idx_q[ADDR_W-1:0];
          idx_d     = idx_inc;
        end else if (pend_q) begin
          ram_we = 1'b1;
          pend_d = 1'b0;
        end else begin
          count_d      = cnt_dec;
          res_d.ok     = 1'b1;
          res_d.length = 5'(cnt_dec);
        end
      end
      ST_RD: begin
        if (!pend_q) begin
          ram_re    = 1'b1;
          ram_raddr = pos_a;
          pend_d    = 1'b1;
        end else begin
          res_d.ok       = 1'b1;
          res_d.data_out = 32'(ram_rdata);
        end
      end
      ST_FIND: begin
        if (hit_now) begin
          res_d.ok       = 1'b1;
          res_d.found_at = 4'(addr_q);
        end else if (!scan_end) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
          pend_d    = 1'b1;
          addr_d    = idx_q[ADDR_W-1:0];
          idx_d     = idx_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    word_q <= word_d;
    idx_q  <= idx_d;
    addr_q <= addr_d;
    res_q  <= res_d;
  end

  a_no_req_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a response is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count beyond depth");

  a_idle_after_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready |=> req_i.ready)
    else $error("not idle after response");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_d == ST_DONE) || (state_q == ST_DONE))
    else $error("entry count changed outside a finishing step");

endmodule
